/* rtl/m3ua_pkg.sv */
// Shared types, codes and the header classifier for the M3UA data message parser.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package m3ua_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int LABEL_BYTES  = 12;

    localparam logic [15:0] TAG_PROTOCOL_DATA = 16'h0210;
    localparam logic [7:0]  VERSION_ONE       = 8'h01;

    // Message kinds.
    localparam logic [2:0] KIND_UNKNOWN = 3'd0;
    localparam logic [2:0] KIND_NOTIFY  = 3'd1;
    localparam logic [2:0] KIND_ASPUP   = 3'd2;
    localparam logic [2:0] KIND_ASPAC   = 3'd3;
    localparam logic [2:0] KIND_DATA    = 3'd4;

    // Summary status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_SHORT       = 3'd1;
    localparam logic [2:0] ST_VERSION     = 3'd2;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
    localparam logic [2:0] ST_NODATA      = 3'd4;
    localparam logic [2:0] ST_OVERRUN     = 3'd5;

    // Result kinds.
    localparam logic RK_PAYLOAD = 1'b0;
    localparam logic RK_SUMMARY = 1'b1;

    // Header class and type codes.
    localparam logic [7:0] CLASS_MGMT = 8'd0;
    localparam logic [7:0] CLASS_XFER = 8'd1;
    localparam logic [7:0] CLASS_ASPSM = 8'd3;
    localparam logic [7:0] CLASS_ASPTM = 8'd4;
    localparam logic [7:0] TYPE_NOTIFY = 8'd1;
    localparam logic [7:0] TYPE_DATA   = 8'd1;
    localparam logic [7:0] TYPE_ASPUP_ACK = 8'd4;
    localparam logic [7:0] TYPE_ASPAC_ACK = 8'd3;

    typedef enum logic [2:0] {
        PH_TAG_HI = 3'd0,
        PH_TAG_LO = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_SKIP   = 3'd4,
        PH_PAD    = 3'd5,
        PH_LABEL  = 3'd6,
        PH_USER   = 3'd7
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_word_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [2:0]  message_kind;
        logic [2:0]  status;
        logic [31:0] origin_point;
        logic [31:0] destination_point;
        logic [7:0]  service_indicator;
        logic [7:0]  network_indicator;
        logic [7:0]  message_priority;
        logic [7:0]  link_selection;
        logic        last_result;
    } out_word_t;

    // One queue entry: what a single input word produced.
    typedef struct packed {
        logic        has_payload;
        logic [7:0]  payload_byte;
        logic        has_summary;
        logic [2:0]  message_kind;
        logic [2:0]  status;
        logic [95:0] label;
    } q_entry_t;

    function automatic logic [2:0] classify(input logic [7:0] cls, input logic [7:0] typ);
        logic [2:0] kind;
        begin
            kind = KIND_UNKNOWN;
            if (cls == CLASS_MGMT && typ == TYPE_NOTIFY)
                kind = KIND_NOTIFY;
            else if (cls == CLASS_ASPSM && typ == TYPE_ASPUP_ACK)
                kind = KIND_ASPUP;
            else if (cls == CLASS_ASPTM && typ == TYPE_ASPAC_ACK)
                kind = KIND_ASPAC;
            else if (cls == CLASS_XFER && typ == TYPE_DATA)
                kind = KIND_DATA;
            return kind;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/m3ua_front.sv */
// Front end: takes message bytes, checks the header and walks the parameters.
// Produces one queue entry per byte that yields a result; uses m3ua_pkg.
`default_nettype none

module m3ua_front #(
    parameter int MAX_MESSAGE_BYTES = 65535
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire m3ua_pkg::in_word_t item,
    output logic                    q_push,
    output m3ua_pkg::q_entry_t      q_data
);
    import m3ua_pkg::*;

    localparam int OFF_W = $clog2(MAX_MESSAGE_BYTES + 1);

    logic [OFF_W-1:0] off_reg, off_next;
    logic [7:0]       cls_reg, cls_next;
    logic [7:0]       typ_reg, typ_next;
    logic [15:0]      tag_reg, tag_next;
    logic [15:0]      rem_reg, rem_next;
    phase_t           phase_reg, phase_next;
    logic [95:0]      label_reg, label_next;
    logic [2:0]       err_reg, err_next;
    logic             seen_reg, seen_next;
    logic             pay_valid;

    logic [7:0]  b;
    logic [1:0]  after2;
    phase_t      end_phase;
    logic [15:0] len;
    logic [15:0] body;
    logic [3:0]  lab;
    logic [15:0] user_cnt;
    logic [15:0] rem_dec;

    assign b         = item.data_byte;
    assign after2    = off_reg[1:0] + 2'd1;
    assign end_phase = (after2 != 2'd0) ? PH_PAD : PH_TAG_HI;
    assign len       = {rem_reg[15:8], b};
    assign body      = (len >= 16'd4) ? (len - 16'd4) : 16'd0;
    assign lab       = (body < 16'(LABEL_BYTES)) ? body[3:0] : 4'(LABEL_BYTES);
    assign user_cnt  = body - {12'd0, lab};
    assign rem_dec   = rem_reg - 16'd1;

    // Next-state logic.
    always_comb
    begin
        off_next   = off_reg;
        cls_next   = cls_reg;
        typ_next   = typ_reg;
        tag_next   = tag_reg;
        rem_next   = rem_reg;
        phase_next = phase_reg;
        label_next = label_reg;
        err_next   = err_reg;
        seen_next  = seen_reg;
        pay_valid  = 1'b0;
        if (accept && off_reg < OFF_W'(MAX_MESSAGE_BYTES))
        begin
            off_next = off_reg + 1'b1;
            if (off_reg == '0)
            begin
                if (b != VERSION_ONE && err_reg == ST_OK)
                    err_next = ST_VERSION;
            end
            else if (off_reg == OFF_W'(2))
            begin
                cls_next = b;
            end
            else if (off_reg == OFF_W'(3))
            begin
                typ_next = b;
                if (classify(cls_reg, b) == KIND_UNKNOWN && err_reg == ST_OK)
                    err_next = ST_UNSUPPORTED;
            end
            else if (off_reg >= OFF_W'(HEADER_BYTES) && err_reg == ST_OK
                     && classify(cls_reg, typ_reg) == KIND_DATA)
            begin
                case (phase_reg)
                    PH_TAG_HI:
                    begin
                        tag_next   = {b, 8'd0};
                        phase_next = PH_TAG_LO;
                    end
                    PH_TAG_LO:
                    begin
                        tag_next   = {tag_reg[15:8], b};
                        phase_next = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        rem_next   = {b, 8'd0};
                        phase_next = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        if (tag_reg == TAG_PROTOCOL_DATA && !seen_reg)
                        begin
                            seen_next  = 1'b1;
                            tag_next   = user_cnt;
                            rem_next   = {12'd0, lab};
                            phase_next = PH_LABEL;
                            // An empty label goes straight on to the user data, or past it when there is none.
                            if (lab == 4'd0)
                            begin
                                rem_next   = user_cnt;
                                phase_next = (user_cnt == 16'd0) ? end_phase : PH_USER;
                            end
                        end
                        else
                        begin
                            rem_next   = body;
                            phase_next = (body == 16'd0) ? end_phase : PH_SKIP;
                        end
                    end
                    PH_SKIP:
                    begin
                        rem_next = rem_dec;
                        if (rem_dec == 16'd0)
                            phase_next = end_phase;
                    end
                    PH_PAD:
                    begin
                        if (after2 == 2'd0)
                            phase_next = PH_TAG_HI;
                    end
                    PH_LABEL:
                    begin
                        label_next = {label_reg[87:0], b};
                        rem_next   = rem_dec;
                        if (rem_dec == 16'd0)
                        begin
                            // The tag register holds the user data count here.
                            rem_next   = tag_reg;
                            phase_next = (tag_reg == 16'd0) ? end_phase : PH_USER;
                        end
                    end
                    PH_USER:
                    begin
                        pay_valid = 1'b1;
                        rem_next  = rem_dec;
                        if (rem_dec == 16'd0)
                            phase_next = end_phase;
                    end
                    default:
                    begin
                        phase_next = PH_TAG_HI;
                    end
                endcase
            end
        end
    end

    // Output logic: the entry for this byte, with the summary taken from the next state.
    always_comb
    begin
        logic [2:0] kind_n;
        logic [2:0] st;
        logic       show_label;
        kind_n     = classify(cls_next, typ_next);
        show_label = 1'b0;
        if (off_next < OFF_W'(HEADER_BYTES))
            st = ST_SHORT;
        else if (err_next != ST_OK)
            st = err_next;
        else if (kind_n != KIND_DATA)
            st = ST_OK;
        else if (!seen_next)
            st = ST_NODATA;
        else
        begin
            show_label = 1'b1;
            st = (phase_next == PH_LABEL || phase_next == PH_USER) ? ST_OVERRUN : ST_OK;
        end

        q_data.has_payload  = pay_valid;
        q_data.payload_byte = b;
        q_data.has_summary  = item.end_of_message;
        q_data.status       = st;
        q_data.label        = show_label ? label_next : 96'd0;
        case (st)
            ST_SHORT, ST_VERSION, ST_UNSUPPORTED: q_data.message_kind = KIND_UNKNOWN;
            default:                              q_data.message_kind = kind_n;
        endcase
        q_push = accept && (pay_valid || item.end_of_message);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg   <= '0;
            cls_reg   <= '0;
            typ_reg   <= '0;
            tag_reg   <= '0;
            rem_reg   <= '0;
            phase_reg <= PH_TAG_HI;
            label_reg <= '0;
            err_reg   <= ST_OK;
            seen_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (item.end_of_message)
            begin
                off_reg   <= '0;
                cls_reg   <= '0;
                typ_reg   <= '0;
                tag_reg   <= '0;
                rem_reg   <= '0;
                phase_reg <= PH_TAG_HI;
                label_reg <= '0;
                err_reg   <= ST_OK;
                seen_reg  <= 1'b0;
            end
            else
            begin
                off_reg   <= off_next;
                cls_reg   <= cls_next;
                typ_reg   <= typ_next;
                tag_reg   <= tag_next;
                rem_reg   <= rem_next;
                phase_reg <= phase_next;
                label_reg <= label_next;
                err_reg   <= err_next;
                seen_reg  <= seen_next;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/m3ua_queue.sv */
// Short queue of parsed entries between the front end and the result stage.
// Read data is registered with a bypass for a write to the next read slot; uses m3ua_pkg.
`default_nettype none

module m3ua_queue #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire m3ua_pkg::q_entry_t wr_data,
    output logic                    full,
    input  wire logic               rd_en,
    output m3ua_pkg::q_entry_t      rd_data,
    output logic                    empty
);
    import m3ua_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t         mem [QUEUE_DEPTH];
    q_entry_t         rd_data_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = rd_data_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
        if (do_wr && wr_ptr_reg == rd_ptr_next)
            rd_data_reg <= wr_data;
        else
            rd_data_reg <= mem[rd_ptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/m3ua_back.sv */
// Result stage: holds one queue entry and hands out its payload word, its summary, or both, payload first.
// Uses m3ua_pkg.
`default_nettype none

module m3ua_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire m3ua_pkg::q_entry_t q_data,
    input  wire logic               q_empty,
    output logic                    q_pop,
    output logic                    empty,
    input  wire logic               pop,
    output m3ua_pkg::out_word_t     result
);
    import m3ua_pkg::*;

    q_entry_t cur_reg;
    logic     valid_reg;
    logic     pay_pend_reg;
    logic     taken, last_piece, cur_free;

    assign empty      = !valid_reg;
    assign taken      = pop && valid_reg;
    assign last_piece = !(pay_pend_reg && cur_reg.has_summary);
    assign cur_free   = !valid_reg || (taken && last_piece);
    assign q_pop      = cur_free && !q_empty;

    always_comb
    begin
        if (pay_pend_reg)
        begin
            result.result_kind  = RK_PAYLOAD;
            result.payload_byte = cur_reg.payload_byte;
            result.message_kind = KIND_DATA;
            result.status       = ST_OK;
            result.last_result  = 1'b0;
            {result.origin_point, result.destination_point, result.service_indicator,
             result.network_indicator, result.message_priority,
             result.link_selection} = 96'd0;
        end
        else
        begin
            result.result_kind  = RK_SUMMARY;
            result.payload_byte = 8'd0;
            result.message_kind = cur_reg.message_kind;
            result.status       = cur_reg.status;
            result.last_result  = 1'b1;
            {result.origin_point, result.destination_point, result.service_indicator,
             result.network_indicator, result.message_priority,
             result.link_selection} = cur_reg.label;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            pay_pend_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg    <= 1'b1;
            pay_pend_reg <= q_data.has_payload;
        end
        else if (cur_free)
        begin
            valid_reg    <= 1'b0;
            pay_pend_reg <= 1'b0;
        end
        else if (taken)
        begin
            // Payload word gone; the summary of the same byte follows.
            pay_pend_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

/* rtl/m3ua_data_message_parser_unit.sv */
// Top level of the M3UA data message parser: front end, entry queue and result stage.
// Depends on m3ua_pkg, m3ua_front, m3ua_queue and m3ua_back.
//
//   channel  | handshake      | word
//   ---------+----------------+------------------------------------------
//   input    | push / full    | item   : message byte, end-of-message flag
//   result   | pop / empty    | result : payload byte or message summary
//
// One byte is taken per cycle while the entry queue has room; the front end
// parses it in that cycle and writes at most one entry.
// A result passes the queue's read register and the result stage's register before
// it is on the result ports; one result goes out per cycle while pop is high and the
// queue holds entries. A byte with payload and summary holds the stage for both.
// Reset clears the parser state and the queue; no clearing pass is needed.
// A stalled result side fills the queue (QUEUE_DEPTH entries) before full rises.
`default_nettype none

module m3ua_data_message_parser_unit #(
    parameter int MAX_MESSAGE_BYTES = 65535,
    parameter int QUEUE_DEPTH       = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire m3ua_pkg::in_word_t  item,
    output logic                     empty,
    input  wire logic                pop,
    output m3ua_pkg::out_word_t      result
);
    import m3ua_pkg::*;

    logic     accept;
    logic     q_push, q_full, q_pop, q_empty;
    q_entry_t q_wr_data, q_rd_data;

    assign full   = q_full;
    assign accept = push && !q_full;

    m3ua_front #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .q_push (q_push),
        .q_data (q_wr_data)
    );

    m3ua_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    m3ua_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_rd_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    // The front end never writes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("entry written while queue full");

    // A payload word always belongs to a clean data message.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.result_kind == RK_PAYLOAD)
            |-> (result.message_kind == KIND_DATA && result.status == ST_OK
                 && !result.last_result))
        else $error("payload word with bad kind or status");

    // Only a summary closes a message.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.last_result == result.result_kind))
        else $error("last flag does not match result kind");

    // A held result word does not change under a stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("stalled result changed");

endmodule

`default_nettype wire
